>>> hdl/tcma_pkg.sv
// Shared constants, types and codes for the three-channel moving average.
`timescale 1ns / 1ps
package tcma_pkg;

	// Window length of every channel
	localparam int WINDOW_LENGTH = 5;

	// Sample as stored in a lane: 16-bit field widened to signed
	localparam int SMP_W = 17;
	// Magnitude of a window sum, and the signed sum itself
	localparam int MAG_W = 16 + $clog2(WINDOW_LENGTH);
	localparam int SUM_W = MAG_W + 1;

	// Divide by WINDOW_LENGTH as multiply by a rounded-up reciprocal and shift
	localparam int DIV_SHIFT = MAG_W + $clog2(WINDOW_LENGTH);
	localparam int MULT_W = MAG_W + 1;
	localparam longint DIV_MULT_L =
		((longint'(1) << DIV_SHIFT) + longint'(WINDOW_LENGTH) - 1) / longint'(WINDOW_LENGTH);
	localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(DIV_MULT_L);
	localparam int PROD_W = MAG_W + MULT_W;

	// Quotient magnitude and signed average / relative result
	localparam int QUOT_W = 16;
	localparam int AVG_W = QUOT_W + 1;
	localparam int ANG_W = 16;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_ORIGIN = 1'b1
	} cmd_t;

	// Per-lane pipeline strobes
	typedef struct packed {
		logic load1;   // transaction accepted, stage 1 loads
		logic push;    // accepted transaction is a sample: window shifts
		logic load2;   // stage 1 moves to stage 2
		logic load3;   // stage 2 moves to stage 3
	} lane_ctrl_t;

endpackage

>>> hdl/tcma_lane.sv
// One channel lane: shift window, running sum and divide by the window length.
`timescale 1ns / 1ps
module tcma_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tcma_pkg::lane_ctrl_t                 ctrl,
	input  logic signed [tcma_pkg::SMP_W-1:0]    sample,
	output logic signed [tcma_pkg::AVG_W-1:0]    avg_s3
);
	import tcma_pkg::*;

	logic signed [SMP_W-1:0]  window_q [WINDOW_LENGTH];
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [SUM_W-1:0]  sum_next;
	logic signed [SUM_W-1:0]  sum_s1;
	logic signed [SUM_W-1:0]  neg_sum;
	logic [MAG_W-1:0]         mag_s2;
	logic                     neg_s2;
	logic [PROD_W-1:0]        prod;
	logic [QUOT_W-1:0]        quot_s3;
	logic                     neg_s3;
	logic signed [AVG_W-1:0]  quot_ext;

	// running sum: add newest, drop oldest
	assign sum_next = sum_q + SUM_W'(sample) - SUM_W'(window_q[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LENGTH; i++) begin
				window_q[i] <= '0;
			end
			sum_q <= '0;
		end else if (ctrl.push) begin
			for (int i = 0; i < WINDOW_LENGTH - 1; i++) begin
				window_q[i] <= window_q[i + 1];
			end
			window_q[WINDOW_LENGTH - 1] <= sample;
			sum_q <= sum_next;
		end
	end

	assign neg_sum = -sum_s1;
	assign prod = PROD_W'(mag_s2) * PROD_W'(DIV_MULT);

	always_ff @(posedge clk) begin
		if (ctrl.load1) begin
			sum_s1 <= ctrl.push ? sum_next : sum_q;
		end
		if (ctrl.load2) begin
			neg_s2 <= sum_s1[SUM_W-1];
			mag_s2 <= sum_s1[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum_s1[MAG_W-1:0];
		end
		if (ctrl.load3) begin
			neg_s3  <= neg_s2;
			quot_s3 <= prod[DIV_SHIFT +: QUOT_W];
		end
	end

	// truncation toward zero: divide the magnitude, restore the sign
	assign quot_ext = {1'b0, quot_s3};
	assign avg_s3 = neg_s3 ? -quot_ext : quot_ext;

endmodule

>>> hdl/tcma_merge.sv
// Merge stage: origin handling, angle offsets and the result register.
`timescale 1ns / 1ps
module tcma_merge (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid,
	input  tcma_pkg::cmd_t                     cmd,
	input  logic signed [tcma_pkg::AVG_W-1:0]  x_avg,
	input  logic signed [tcma_pkg::AVG_W-1:0]  y_avg,
	input  logic signed [tcma_pkg::AVG_W-1:0]  h_avg,
	output logic                               ready,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic signed [tcma_pkg::AVG_W-1:0]  x_relative,
	output logic signed [tcma_pkg::AVG_W-1:0]  y_relative,
	output logic [tcma_pkg::QUOT_W-1:0]        height_average
);
	import tcma_pkg::*;

	logic                     load;
	logic signed [ANG_W-1:0]  last_x_q;
	logic signed [ANG_W-1:0]  last_y_q;
	logic signed [ANG_W-1:0]  origin_x_q;
	logic signed [ANG_W-1:0]  origin_y_q;

	assign ready = !result_valid || !result_stall;
	assign load  = valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			last_x_q     <= '0;
			last_y_q     <= '0;
			origin_x_q   <= '0;
			origin_y_q   <= '0;
		end else begin
			if (load) begin
				result_valid <= (cmd == CMD_SAMPLE);
			end else begin
				result_valid <= result_valid && result_stall;
			end
			if (load && cmd == CMD_ORIGIN) begin
				origin_x_q <= last_x_q;
				origin_y_q <= last_y_q;
			end
			if (load && cmd == CMD_SAMPLE) begin
				last_x_q <= x_avg[ANG_W-1:0];
				last_y_q <= y_avg[ANG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && cmd == CMD_SAMPLE) begin
			x_relative     <= x_avg - AVG_W'(origin_x_q);
			y_relative     <= y_avg - AVG_W'(origin_y_q);
			height_average <= h_avg[QUOT_W-1:0];
		end
	end

endmodule

>>> hdl/three_channel_moving_average.sv
// Top level: three-channel boxcar moving average with a settable angle origin.
`timescale 1ns / 1ps
// Usage
//   Sample channel: sample_valid / sample_stall with command, angle_x, angle_y,
//   height. A transaction is taken on a rising edge with valid high, stall low.
//   command = sample shifts the three windows and yields one result;
//   command = origin copies the latest angle averages into the origin and
//   yields no result.
//   Result channel: result_valid / result_stall with x_relative, y_relative,
//   height_average (window averages, angles relative to the origin).
// Pipeline: a result passes the window/sum, abs, reciprocal multiply and merge
//   registers in that order; a stalled result channel holds it in the merge.
// Throughput: one transaction per cycle while sample_stall is low; the
//   running-sum update in each lane is the only loop.
// Stall: each stage holds its data while the next stage is full, so input is
//   still taken while empty stages remain; sample_stall rises only once the
//   whole pipeline is full behind a stalled result.
// Reset: arst_n clears windows, running sums, last averages, origin and all
//   valid flags; the block takes input right after reset.
module three_channel_moving_average (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic                               command,
	input  logic signed [15:0]                 angle_x,
	input  logic signed [15:0]                 angle_y,
	input  logic [15:0]                        height,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic signed [tcma_pkg::AVG_W-1:0]  x_relative,
	output logic signed [tcma_pkg::AVG_W-1:0]  y_relative,
	output logic [tcma_pkg::QUOT_W-1:0]        height_average
);
	import tcma_pkg::*;

	// pipeline occupancy and command code per stage
	logic        valid_s1, valid_s2, valid_s3;
	cmd_t        cmd_s1, cmd_s2, cmd_s3;
	cmd_t        cmd_in;

	// ready chain, back to front
	logic        merge_ready;
	logic        ready2;      // stage 3 can load
	logic        ready1;      // stage 2 can load
	logic        accept;

	lane_ctrl_t  ctrl;

	logic signed [SMP_W-1:0]  x_sample, y_sample, h_sample;
	logic signed [AVG_W-1:0]  x_avg, y_avg, h_avg;

	assign cmd_in = cmd_t'(command);

	assign ready2       = !valid_s3 || merge_ready;
	assign ready1       = !valid_s2 || ready2;
	assign sample_stall = valid_s1 && !ready1;
	assign accept       = sample_valid && !sample_stall;

	assign ctrl.load1 = accept;
	assign ctrl.push  = accept && (cmd_in == CMD_SAMPLE);
	assign ctrl.load2 = valid_s1 && ready1;
	assign ctrl.load3 = valid_s2 && ready2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept     || (valid_s1 && !ctrl.load2);
			valid_s2 <= ctrl.load2 || (valid_s2 && !ctrl.load3);
			valid_s3 <= ctrl.load3 || (valid_s3 && !merge_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load1) begin
			cmd_s1 <= cmd_in;
		end
		if (ctrl.load2) begin
			cmd_s2 <= cmd_s1;
		end
		if (ctrl.load3) begin
			cmd_s3 <= cmd_s2;
		end
	end

	// angles sign-extend, height zero-extends into the common lane format
	assign x_sample = SMP_W'(angle_x);
	assign y_sample = SMP_W'(angle_y);
	assign h_sample = {1'b0, height};

	tcma_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (x_sample),
		.avg_s3 (x_avg)
	);

	tcma_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (y_sample),
		.avg_s3 (y_avg)
	);

	tcma_lane u_lane_h (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (h_sample),
		.avg_s3 (h_avg)
	);

	// origin commands and results meet the merge stage in arrival order
	tcma_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid          (valid_s3),
		.cmd            (cmd_s3),
		.x_avg          (x_avg),
		.y_avg          (y_avg),
		.h_avg          (h_avg),
		.ready          (merge_ready),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.x_relative     (x_relative),
		.y_relative     (y_relative),
		.height_average (height_average)
	);

endmodule

>>> hdl/tcma_checker.sv
// Port-level checker for the moving average top level, with its bind.
`timescale 1ns / 1ps
module tcma_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               sample_valid,
	input logic                               sample_stall,
	input logic                               command,
	input logic                               result_valid,
	input logic                               result_stall,
	input logic signed [tcma_pkg::AVG_W-1:0]  x_relative,
	input logic signed [tcma_pkg::AVG_W-1:0]  y_relative,
	input logic [tcma_pkg::QUOT_W-1:0]        height_average
);
	import tcma_pkg::*;

	// stalled result stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// stalled result payload holds
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(x_relative) && $stable(y_relative)
			&& $stable(height_average))
		else $error("result payload changed while stalled");

	// with no result pending the pipeline always has room
	a_no_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !sample_stall)
		else $error("input stalled with result channel idle");

	// an accepted sample reaches the output when result_stall stays low behind it
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall && (command == CMD_SAMPLE))
			##1 !result_stall ##1 !result_stall ##1 !result_stall |=> result_valid)
		else $error("sample result late");

endmodule

bind three_channel_moving_average tcma_checker u_tcma_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.sample_valid   (sample_valid),
	.sample_stall   (sample_stall),
	.command        (command),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.x_relative     (x_relative),
	.y_relative     (y_relative),
	.height_average (height_average)
);
